// File: rtl/core/pft_pkg.sv
`default_nettype none

package pft_pkg;

    // Longest varint that the wire format allows
    localparam int unsigned VARINT_MAX_BYTES = 10;

    localparam logic [15:0] MAX_LEN_RESET = 16'hffff;

    // Result kinds
    localparam logic [1:0] KIND_INTEGER = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_NONCANON  = 3'd3;
    localparam logic [2:0] ERR_BAD_TAG   = 3'd4;
    localparam logic [2:0] ERR_BAD_LEN   = 3'd5;
    localparam logic [2:0] ERR_BAD_WT    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [28:0] field_number;
        logic [1:0]  wire_code;
        logic [63:0] field_value;
        logic [7:0]  payload_data;
        logic        payload_final;
        logic [2:0]  error_code;
        logic        end_of_message;
    } t_out_item;

    // Result handed from the decoder to the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/pft_in_stage.sv
`default_nettype none

module pft_in_stage
    import pft_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_consume,
    output logic          o_stall,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     take;

    // Refill whenever the held byte leaves or the slot is empty
    assign take    = !r_valid || i_consume;
    assign o_stall = !take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pft_decode.sv
`default_nettype none

module pft_decode
    import pft_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    input  wire t_in_item    i_item,
    input  wire logic        i_out_ready,
    output logic             o_consume,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DRAIN
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_idx, n_idx;
    logic [28:0] r_fnum, n_fnum;
    logic [15:0] r_left, n_left;
    logic [15:0] r_max_len;

    logic [5:0]  shamt;
    logic [63:0] merged;
    logic [15:0] left_dec;
    logic        is_len;
    logic        fault;
    logic [2:0]  fault_code;
    t_result     res;
    logic [7:0]  b;
    logic        e;

    assign b        = i_item.data_byte;
    assign e        = i_item.message_end;
    assign is_len   = (r_phase == PH_LENGTH);
    assign shamt    = 6'({2'b00, r_idx} * 6'd7);
    assign merged   = r_acc | (64'(b[6:0]) << shamt);
    assign left_dec = (r_left != 16'd0) ? (r_left - 16'd1) : r_left;

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_fnum     = r_fnum;
        n_left     = r_left;
        fault      = 1'b0;
        fault_code = ERR_NONE;
        res        = '0;

        unique case (r_phase)
            PH_DRAIN: begin
                if (e) begin
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_idx   = '0;
                end
            end
            PH_PAYLOAD: begin
                n_left = left_dec;
                if (left_dec == 16'd0) begin
                    n_phase                   = PH_TAG;
                    res.valid                 = 1'b1;
                    res.item.item_kind        = KIND_PAYLOAD;
                    res.item.field_number     = r_fnum;
                    res.item.wire_code        = WT_LEN[1:0];
                    res.item.payload_data     = b;
                    res.item.payload_final    = 1'b1;
                    res.item.end_of_message   = e;
                end else if (e) begin
                    fault      = 1'b1;
                    fault_code = ERR_BAD_LEN;
                end else begin
                    res.valid                 = 1'b1;
                    res.item.item_kind        = KIND_PAYLOAD;
                    res.item.field_number     = r_fnum;
                    res.item.wire_code        = WT_LEN[1:0];
                    res.item.payload_data     = b;
                end
            end
            PH_TAG, PH_VALUE, PH_LENGTH: begin
                priority if (r_idx >= 4'(VARINT_MAX_BYTES)) begin
                    fault      = 1'b1;
                    fault_code = is_len ? ERR_BAD_LEN : ERR_OVERFLOW;
                end else if (r_idx == 4'(VARINT_MAX_BYTES - 1) && b[7:1] != 7'd0) begin
                    fault      = 1'b1;
                    fault_code = is_len ? ERR_BAD_LEN : ERR_OVERFLOW;
                end else if (b[7]) begin
                    if (e) begin
                        fault      = 1'b1;
                        fault_code = is_len ? ERR_BAD_LEN : ERR_TRUNCATED;
                    end else begin
                        n_acc = merged;
                        n_idx = r_idx + 4'd1;
                    end
                end else if (r_idx != 4'd0 && b[6:0] == 7'd0) begin
                    fault      = 1'b1;
                    fault_code = is_len ? ERR_BAD_LEN : ERR_NONCANON;
                end else begin
                    // Varint complete: merged holds its value
                    n_acc = '0;
                    n_idx = '0;
                    if (r_phase == PH_TAG) begin
                        if (merged == 64'd0 || merged[63:32] != 32'd0) begin
                            fault      = 1'b1;
                            fault_code = ERR_BAD_TAG;
                        end else begin
                            n_fnum = merged[31:3];
                            if (merged[2:0] == WT_VARINT) begin
                                if (e) begin
                                    fault      = 1'b1;
                                    fault_code = ERR_TRUNCATED;
                                end else begin
                                    n_phase = PH_VALUE;
                                end
                            end else if (merged[2:0] == WT_LEN) begin
                                if (e) begin
                                    fault      = 1'b1;
                                    fault_code = ERR_BAD_LEN;
                                end else begin
                                    n_phase = PH_LENGTH;
                                end
                            end else begin
                                fault      = 1'b1;
                                fault_code = ERR_BAD_WT;
                            end
                        end
                    end else if (r_phase == PH_VALUE) begin
                        n_phase                 = PH_TAG;
                        res.valid               = 1'b1;
                        res.item.item_kind      = KIND_INTEGER;
                        res.item.field_number   = r_fnum;
                        res.item.wire_code      = WT_VARINT[1:0];
                        res.item.field_value    = merged;
                        res.item.end_of_message = e;
                    end else begin
                        if (merged[63:16] != 48'd0 || merged[15:0] > r_max_len) begin
                            fault      = 1'b1;
                            fault_code = ERR_BAD_LEN;
                        end else if (merged == 64'd0) begin
                            n_phase                 = PH_TAG;
                            res.valid               = 1'b1;
                            res.item.item_kind      = KIND_HEADER;
                            res.item.field_number   = r_fnum;
                            res.item.wire_code      = WT_LEN[1:0];
                            res.item.end_of_message = e;
                        end else if (e) begin
                            fault      = 1'b1;
                            fault_code = ERR_BAD_LEN;
                        end else begin
                            n_phase               = PH_PAYLOAD;
                            n_left                = merged[15:0];
                            res.valid             = 1'b1;
                            res.item.item_kind    = KIND_HEADER;
                            res.item.field_number = r_fnum;
                            res.item.wire_code    = WT_LEN[1:0];
                            res.item.field_value  = merged;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_TAG;
                n_acc   = '0;
                n_idx   = '0;
            end
        endcase

        // Error: report, clear varint state, drop the rest of the message
        if (fault) begin
            n_acc                   = '0;
            n_idx                   = '0;
            n_phase                 = e ? PH_TAG : PH_DRAIN;
            res                     = '0;
            res.valid               = 1'b1;
            res.item.item_kind      = KIND_ERROR;
            res.item.error_code     = fault_code;
            res.item.end_of_message = e;
        end
    end

    // Advance when the output has room or this byte gives no result
    assign o_consume      = i_valid && (i_out_ready || !res.valid);
    assign o_result.valid = o_consume && res.valid;
    assign o_result.item  = res.item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_acc     <= '0;
            r_idx     <= '0;
            r_fnum    <= '0;
            r_left    <= '0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (o_consume) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_idx   <= n_idx;
                r_fnum  <= n_fnum;
                r_left  <= n_left;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pft_out_stage.sv
`default_nettype none

module pft_out_stage
    import pft_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_ready,
    output logic         o_valid,
    output t_out_item    o_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_item <= i_result.item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/protobuf_field_tokenizer_top.sv
// Protobuf field tokenizer: takes an encoded message one byte per transfer
// (message_end marks its last byte) and returns at most one result per byte:
// an integer field, a bytes-field header carrying its length, each payload
// byte (the last one flagged payload_final), or an error. Tags must be
// nonzero with field numbers below 2^29 and wire type 0 or 2; varints that
// are truncated, overlong or noncanonical are rejected, as are lengths above
// max_field_length. After an error every byte up to the end of the message
// is dropped silently. Throughput is one byte per clock while the output is
// not stalled: the tokenizer state (phase, varint accumulator, payload
// count) is updated by one short decode stage per byte. An input transfer
// passes through the input register and then the result register before
// its result appears. Bytes that give no result do not wait for output
// room. max_field_length must be written only while the block is idle.
`default_nettype none

module protobuf_field_tokenizer_top
    import pft_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: one register, written when the enable is high
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    // byte input
    input  wire logic        i_in_valid,
    input  wire t_in_item    i_in_item,
    output logic             o_in_stall,
    // result output
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  wire logic        i_out_stall
);

    logic     in_valid;
    t_in_item in_item;
    logic     consume;
    logic     out_ready;
    t_result  result;

    // Hold the accepted byte until the decoder takes it
    pft_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (i_in_item),
        .i_consume (consume),
        .o_stall   (o_in_stall),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    // Decode one byte against the tokenizer state and advance it
    pft_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (in_valid),
        .i_item        (in_item),
        .i_out_ready   (out_ready),
        .o_consume     (consume),
        .o_result      (result)
    );

    // Register the result; it frees as soon as the consumer drops stall
    pft_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item)
    );

endmodule

`default_nettype wire
